>>> design/pats_pkg.sv
package pats_pkg;

    // Command codes
    typedef enum logic [3:0] {
        FN_ADD     = 4'd0,
        FN_KILL    = 4'd1,
        FN_SLEEP   = 4'd2,
        FN_TICK    = 4'd3,
        FN_SCHED   = 4'd4,
        FN_SEMINIT = 4'd5,
        FN_WAIT    = 4'd6,
        FN_SIGNAL  = 4'd7,
        FN_BWAIT   = 4'd8,
        FN_BSIGNAL = 4'd9,
        FN_TRY     = 4'd10,
        FN_BTRY    = 4'd11,
        FN_WAKE    = 4'd12
    } func_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SIG,
        ST_FIND,
        ST_DONE
    } state_t;

    localparam logic [7:0] PRIO_NONE       = 8'd255;
    localparam logic [7:0] AGE_MAX         = 8'd255;
    localparam logic [7:0] AGE_LIMIT_RESET = 8'd8;

    // Saturating signed 8-bit add of a small step
    function automatic logic signed [7:0] sat8_add(input logic signed [7:0] a,
                                                   input logic signed [1:0] d);
        logic signed [8:0] s;
        s = 9'(a) + 9'(d);
        if (s > 9'sd127)
            return 8'sd127;
        else if (s < -9'sd128)
            return -8'sd128;
        else
            return s[7:0];
    endfunction

endpackage

>>> design/pats_slot_eval.sv
// Evaluates one thread slot per cycle for the shared scan unit
module pats_slot_eval
    import pats_pkg::*;
(
    input  logic        used,
    input  logic [15:0] sleep_in,
    input  logic        blocked,
    input  logic [7:0]  wprio,
    input  logic [7:0]  best_prio,
    input  logic [7:0]  age_in,
    input  logic [7:0]  age_limit,
    output logic        better,
    output logic [15:0] sleep_dec,
    output logic [7:0]  age_inc,
    output logic        prio_drop
);
    logic eligible;

    always_comb begin
        eligible  = used && (sleep_in == 16'd0) && !blocked;
        better    = eligible && (wprio < best_prio);
        sleep_dec = (sleep_in != 16'd0) ? sleep_in - 16'd1 : sleep_in;
        age_inc   = (age_in < AGE_MAX) ? age_in + 8'd1 : age_in;
        prio_drop = (age_inc > age_limit) && (wprio != 8'd0);
    end
endmodule

>>> design/priority_aging_thread_scheduler_core.sv
// add/kill/sleep/wake/seminit/wait/bwait/try/btry go from acceptance straight to
// the result state; tick and schedule scan THREADS slots, one per cycle; bsignal
// searches the other slots for a blocked thread; signal runs signal_count rounds,
// each bumping the semaphore and, while it stays nonpositive, searching as well.
// One command at a time; s_tready returns the cycle after the result word is taken.
// aresetn (synchronous, active low) frees all slots, zeroes semaphores, counters.
module priority_aging_thread_scheduler_core
    import pats_pkg::*;
#(
    parameter int THREADS    = 16,
    parameter int SEMAPHORES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // func[3:0] priority_req[11:4] sleep_ms[27:12] sem_index[30:28]
    // init_value[38:31] signal_count[42:39] target_thread[46:43], zero pad
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // ok[0] thread_id[4:1] switch_request[5] no_thread[6] old_value[14:7]
    // ms_time[46:15], zero pad
    output logic [47:0] m_tdata
);
    localparam int TW = $clog2(THREADS);
    localparam int SW = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;
    localparam int CW = $clog2(THREADS + 1);

    // Per-slot table (flops, at most one slot touched per cycle)
    logic [THREADS-1:0] used_reg;
    logic [7:0]  base_reg  [THREADS];
    logic [7:0]  wprio_reg [THREADS];
    logic [7:0]  age_reg   [THREADS];
    logic [15:0] sleep_reg [THREADS];
    logic [5:0]  blk_reg   [THREADS];
    logic signed [7:0] sem_reg [SEMAPHORES];

    logic [TW-1:0] cur_reg;
    logic [CW-1:0] count_reg;
    logic [31:0]   ms_reg;
    logic [7:0]    age_limit_reg;
    state_t        state_reg;

    // Latched command
    logic [3:0]  fn_reg;
    logic [7:0]  prio_req_reg;
    logic [15:0] sleep_ms_reg;
    logic [2:0]  sidx_reg;
    logic signed [7:0] init_reg;
    logic [3:0]  scount_reg;
    logic [3:0]  target_reg;
    logic        cur_live_reg;

    // Scan unit state
    logic [CW-1:0] k_reg;
    logic [TW-1:0] best_reg;
    logic          found_reg;
    logic [7:0]    bestp_reg;
    logic [3:0]    rounds_reg;

    // Result register
    logic        ok_reg, sw_reg, none_reg;
    logic [3:0]  tid_reg;
    logic signed [7:0] oldv_reg;
    logic        mv_reg;

    assign s_tready = (state_reg == ST_IDLE) && !mv_reg;
    assign m_tvalid = mv_reg;
    assign m_tdata  = {1'b0, ms_reg, oldv_reg, none_reg, sw_reg, tid_reg, ok_reg};

    wire in_acc = s_tvalid && s_tready;

    // Current scan slot: (cur + k) mod THREADS
    logic [TW:0]   sum;
    logic [TW-1:0] idx;
    always_comb begin
        sum = {1'b0, cur_reg} + (TW+1)'(k_reg);
        idx = (sum >= (TW+1)'(THREADS)) ? TW'(sum - (TW+1)'(THREADS)) : sum[TW-1:0];
    end

    logic sem_ok;
    logic [SW-1:0] sidx;
    logic [5:0] tag;
    assign sem_ok = 32'(sidx_reg) < SEMAPHORES;
    assign sidx   = sem_ok ? SW'(sidx_reg) : '0;
    assign tag    = 6'(sidx) + 6'd1;

    // Scanned slot is live and blocked on the addressed semaphore
    logic hit;
    assign hit = used_reg[idx] && (blk_reg[idx] == tag);

    logic better, pdrop;
    logic [15:0] sdec;
    logic [7:0] ainc;
    pats_slot_eval u_eval (
        .used(used_reg[idx]), .sleep_in(sleep_reg[idx]), .blocked(blk_reg[idx] != 6'd0),
        .wprio(wprio_reg[idx]), .best_prio(bestp_reg), .age_in(age_reg[idx]),
        .age_limit(age_limit_reg), .better(better),
        .sleep_dec(sdec), .age_inc(ainc), .prio_drop(pdrop)
    );

    // Lowest free slot (priority encode)
    logic [TW-1:0] free_idx;
    logic          free_any;
    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = THREADS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_idx = TW'(i);
                free_any = 1'b1;
            end
        end
    end

    logic signed [7:0] semv;
    logic signed [7:0] sem_inc;
    assign semv    = sem_reg[sidx];
    assign sem_inc = sat8_add(semv, 2'sd1);

    // Next-state logic
    state_t state_next;
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_acc) begin
                // tick and schedule go to scan, bsignal to find, signal to sig
                if (s_tdata[3:0] == FN_TICK || s_tdata[3:0] == FN_SCHED)
                    state_next = ST_SCAN;
                else if (s_tdata[3:0] == FN_BSIGNAL)
                    state_next = ST_FIND;
                else if (s_tdata[3:0] == FN_SIGNAL)
                    state_next = ST_SIG;
                else
                    state_next = ST_DONE;
            end
            ST_SCAN: if (32'(k_reg) == THREADS) state_next = ST_DONE;
            ST_SIG: begin
                // bump; search only while the value stays nonpositive
                if (rounds_reg == 4'd0 || !sem_ok)
                    state_next = ST_DONE;
                else if (sem_inc <= 8'sd0)
                    state_next = ST_FIND;
                else if (rounds_reg == 4'd1)
                    state_next = ST_DONE;
            end
            ST_FIND: begin
                if (fn_reg == FN_SIGNAL) begin
                    if (hit || 32'(k_reg) == THREADS)
                        state_next = (rounds_reg == 4'd0) ? ST_DONE : ST_SIG;
                end else if (!sem_ok || 32'(k_reg) == THREADS || hit) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            cur_reg       <= '0;
            count_reg     <= '0;
            ms_reg        <= '0;
            age_limit_reg <= AGE_LIMIT_RESET;
            mv_reg        <= 1'b0;
            for (int i = 0; i < SEMAPHORES; i++) sem_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) age_limit_reg <= cfg_wdata;
            if (mv_reg && m_tready) mv_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE: if (in_acc) begin
                    fn_reg       <= s_tdata[3:0];
                    prio_req_reg <= s_tdata[11:4];
                    sleep_ms_reg <= s_tdata[27:12];
                    sidx_reg     <= s_tdata[30:28];
                    init_reg     <= s_tdata[38:31];
                    scount_reg   <= s_tdata[42:39];
                    target_reg   <= s_tdata[46:43];
                    cur_live_reg <= used_reg[cur_reg];
                    ok_reg <= 1'b0; sw_reg <= 1'b0; none_reg <= 1'b0;
                    tid_reg <= '0; oldv_reg <= '0;
                    k_reg <= CW'(1);
                    found_reg <= 1'b0;
                    bestp_reg <= PRIO_NONE;
                    best_reg  <= '0;
                    rounds_reg <= s_tdata[42:39];
                end
                ST_SCAN: begin
                    k_reg <= k_reg + CW'(1);
                    if (fn_reg == FN_TICK) begin
                        if (used_reg[idx]) begin
                            sleep_reg[idx] <= sdec;
                            if (!(cur_live_reg && idx == cur_reg) && sdec == 16'd0
                                && blk_reg[idx] == 6'd0) begin
                                age_reg[idx] <= ainc;
                                if (pdrop) wprio_reg[idx] <= wprio_reg[idx] - 8'd1;
                            end
                        end
                        if (32'(k_reg) == THREADS) ms_reg <= ms_reg + 32'd1;
                    end else begin
                        if (better) begin
                            best_reg  <= idx;
                            bestp_reg <= wprio_reg[idx];
                            found_reg <= 1'b1;
                        end
                        if (32'(k_reg) == THREADS) begin
                            if (better || found_reg) begin
                                cur_reg <= better ? idx : best_reg;
                                age_reg[better ? idx : best_reg] <= '0;
                                wprio_reg[better ? idx : best_reg] <=
                                    base_reg[better ? idx : best_reg];
                                tid_reg <= 4'(better ? idx : best_reg);
                            end else begin
                                none_reg <= 1'b1;
                            end
                        end
                    end
                end
                ST_SIG: begin
                    // one signal round: bump the value
                    k_reg <= CW'(1);
                    if (rounds_reg != 4'd0 && sem_ok) begin
                        rounds_reg <= rounds_reg - 4'd1;
                        sem_reg[sidx] <= sem_inc;
                    end
                end
                ST_FIND: begin
                    k_reg <= k_reg + CW'(1);
                    if (fn_reg == FN_SIGNAL) begin
                        if (hit) blk_reg[idx] <= '0;
                    end else if (sem_ok) begin
                        // binary signal excludes current slot
                        if (32'(k_reg) == THREADS) begin
                            sem_reg[sidx] <= 8'sd1;
                        end else if (hit) begin
                            blk_reg[idx] <= '0;
                            sem_reg[sidx] <= 8'sd0;
                        end
                    end
                end
                ST_DONE: begin
                    mv_reg <= 1'b1;
                    unique case (fn_reg)
                        FN_ADD: if (32'(count_reg) < THREADS && free_any) begin
                            if (count_reg == '0) cur_reg <= free_idx;
                            used_reg[free_idx]  <= 1'b1;
                            base_reg[free_idx]  <= prio_req_reg;
                            wprio_reg[free_idx] <= prio_req_reg;
                            age_reg[free_idx]   <= '0;
                            sleep_reg[free_idx] <= '0;
                            blk_reg[free_idx]   <= '0;
                            count_reg <= count_reg + CW'(1);
                            ok_reg  <= 1'b1;
                            tid_reg <= 4'(free_idx);
                        end
                        FN_KILL: if (cur_live_reg) begin
                            used_reg[cur_reg] <= 1'b0;
                            if (count_reg != '0) count_reg <= count_reg - CW'(1);
                            sw_reg <= 1'b1;
                        end
                        FN_SLEEP: if (cur_live_reg) begin
                            sleep_reg[cur_reg] <= sleep_ms_reg;
                            sw_reg <= 1'b1;
                        end
                        FN_SEMINIT: if (sem_ok) sem_reg[sidx] <= init_reg;
                        FN_WAIT: if (sem_ok && cur_live_reg) begin
                            sem_reg[sidx] <= sat8_add(semv, -2'sd1);
                            if (sat8_add(semv, -2'sd1) < 8'sd0) begin
                                blk_reg[cur_reg] <= tag;
                                sw_reg <= 1'b1;
                            end
                        end
                        FN_BWAIT: if (sem_ok && cur_live_reg) begin
                            if (semv == 8'sd1) sem_reg[sidx] <= 8'sd0;
                            else begin
                                blk_reg[cur_reg] <= tag;
                                sw_reg <= 1'b1;
                            end
                        end
                        FN_TRY: if (sem_ok) begin
                            oldv_reg <= semv;
                            if (semv > 8'sd0) begin
                                sem_reg[sidx] <= semv - 8'sd1;
                                ok_reg <= 1'b1;
                            end
                        end
                        FN_BTRY: if (sem_ok) begin
                            oldv_reg <= semv;
                            sem_reg[sidx] <= 8'sd0;
                            ok_reg <= (semv != 8'sd0);
                        end
                        FN_WAKE: if (32'(target_reg) < THREADS)
                            sleep_reg[TW'(target_reg)] <= '0;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end
endmodule

>>> design/pats_checker.sv
module pats_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);
    // Output word holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Never ready while a result waits
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("ready with pending result");

    // No result in the cycle after a word is accepted
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !m_tvalid) else $error("result too early");

    // Flags exclusive: no_thread never with ok
    a_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[6] && m_tdata[0])) else $error("no_thread with ok");
endmodule

bind priority_aging_thread_scheduler_core pats_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

>>> test/tb_priority_aging_thread_scheduler_core.sv
module tb_priority_aging_thread_scheduler_core;
    import pats_pkg::*;

    localparam int NSLOT = 16;
    localparam int NSEM = 8;
    localparam int WATCHDOG = 20000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;

    priority_aging_thread_scheduler_core uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    typedef struct packed {
        logic [3:0]  target;
        logic [3:0]  scount;
        logic [7:0]  init_v;
        logic [2:0]  sidx;
        logic [15:0] sleep_ms;
        logic [7:0]  prio;
        logic [3:0]  fn;
    } cmd_t;

    typedef struct packed {
        logic [31:0] ms;
        logic [7:0]  oldv;
        logic        none;
        logic        sw;
        logic [3:0]  tid;
        logic        ok;
    } res_t;

    // scheduler shadow state
    logic [7:0]  age_lim;
    logic        used [NSLOT];
    logic [7:0]  basep [NSLOT];
    logic [7:0]  workp [NSLOT];
    logic [7:0]  age [NSLOT];
    logic [15:0] sleep_cnt [NSLOT];
    logic [3:0]  blk [NSLOT];
    int          semv [NSEM];
    logic [3:0]  cur;
    int          nthreads;
    logic [31:0] ms_cnt;

    res_t        sched_results[$];
    int          errors;
    int          shown;
    int          idle_cycles;
    bit          gaps_on;

    function automatic int sat8(int v);
        if (v > 127) return 127;
        if (v < -128) return -128;
        return v;
    endfunction

    // first used slot waiting on tag, from cur+1
    function automatic int blocked_slot(logic [3:0] tag, bit with_cur);
        int s;
        for (int k = 1; k <= NSLOT; k++) begin
            s = (cur + k) % NSLOT;
            if (k == NSLOT && !with_cur) break;
            if (used[s] && blk[s] == tag) return s;
        end
        return NSLOT;
    endfunction

    task automatic sched_reset();
        age_lim = AGE_LIMIT_RESET;
        for (int i = 0; i < NSLOT; i++) begin
            used[i] = 0; basep[i] = 0; workp[i] = 0; age[i] = 0;
            sleep_cnt[i] = 0; blk[i] = 0;
        end
        for (int i = 0; i < NSEM; i++) semv[i] = 0;
        cur = 0;
        nthreads = 0;
        ms_cnt = 0;
    endtask

    // apply one command to the shadow state, return the expected result word
    function automatic res_t sched_step(cmd_t c);
        res_t r;
        bit live;
        int s, t, best, bestp, oldv, i;
        r = '0;
        live = used[cur];
        s = c.sidx;
        oldv = 0;
        case (c.fn)
            FN_ADD: begin
                if (nthreads < NSLOT) begin
                    for (i = 0; i < NSLOT; i++) if (!used[i]) break;
                    if (i < NSLOT) begin
                        if (nthreads == 0) cur = 4'(i);
                        used[i] = 1; basep[i] = c.prio; workp[i] = c.prio;
                        age[i] = 0; sleep_cnt[i] = 0; blk[i] = 0;
                        nthreads++;
                        r.ok = 1; r.tid = 4'(i);
                    end
                end
            end
            FN_KILL: if (live) begin
                used[cur] = 0;
                if (nthreads > 0) nthreads--;
                r.sw = 1;
            end
            FN_SLEEP: if (live) begin
                sleep_cnt[cur] = c.sleep_ms;
                r.sw = 1;
            end
            FN_TICK: begin
                ms_cnt++;
                for (i = 0; i < NSLOT; i++)
                    if (used[i] && sleep_cnt[i] > 0) sleep_cnt[i]--;
                for (i = 0; i < NSLOT; i++) begin
                    if (!used[i] || (live && i == cur)) continue;
                    if (sleep_cnt[i] == 0 && blk[i] == 0) begin
                        if (age[i] < AGE_MAX) age[i]++;
                        if (age[i] > age_lim && workp[i] > 0) workp[i]--;
                    end
                end
            end
            FN_SCHED: begin
                best = NSLOT; bestp = PRIO_NONE;
                for (int k = 1; k <= NSLOT; k++) begin
                    t = (cur + k) % NSLOT;
                    if (used[t] && sleep_cnt[t] == 0 && blk[t] == 0 && workp[t] < bestp) begin
                        best = t; bestp = workp[t];
                    end
                end
                if (best < NSLOT) begin
                    cur = 4'(best); age[best] = 0; workp[best] = basep[best];
                    r.tid = 4'(best);
                end else begin
                    r.none = 1;
                end
            end
            FN_SEMINIT: semv[s] = $signed(c.init_v);
            FN_WAIT: if (live) begin
                semv[s] = sat8(semv[s] - 1);
                if (semv[s] < 0) begin
                    blk[cur] = 4'(s + 1); r.sw = 1;
                end
            end
            FN_SIGNAL: for (i = 0; i < c.scount; i++) begin
                semv[s] = sat8(semv[s] + 1);
                if (semv[s] <= 0) begin
                    t = blocked_slot(4'(s + 1), 1);
                    if (t < NSLOT) blk[t] = 0;
                end
            end
            FN_BWAIT: if (live) begin
                if (semv[s] == 1) semv[s] = 0;
                else begin
                    blk[cur] = 4'(s + 1); r.sw = 1;
                end
            end
            FN_BSIGNAL: begin
                t = blocked_slot(4'(s + 1), 0);
                semv[s] = 1;
                if (t < NSLOT) begin
                    blk[t] = 0; semv[s] = 0;
                end
            end
            FN_TRY: begin
                oldv = semv[s];
                if (oldv > 0) begin
                    semv[s] = oldv - 1; r.ok = 1;
                end
            end
            FN_BTRY: begin
                oldv = semv[s];
                semv[s] = 0;
                r.ok = (oldv != 0);
            end
            FN_WAKE: sleep_cnt[c.target] = 0;
            default: ;
        endcase
        r.oldv = oldv[7:0];
        r.ms = ms_cnt;
        return r;
    endfunction

    // clock
    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    // result checker and receiver stalls
    int stall_left;
    initial stall_left = 0;
    always @(posedge aclk) begin
        res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[46:0];
            if (sched_results.size() == 0) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("unexpected result word %h", got);
                end
            end else begin
                want = sched_results.pop_front();
                if (got !== want) begin
                    errors++;
                    if (shown < 10) begin
                        shown++;
                        $display("mismatch: exp ok=%0d tid=%0d sw=%0d none=%0d old=%0d ms=%0d",
                            want.ok, want.tid, want.sw, want.none,
                            $signed(want.oldv), want.ms);
                        $display("          got ok=%0d tid=%0d sw=%0d none=%0d old=%0d ms=%0d",
                            got.ok, got.tid, got.sw, got.none,
                            $signed(got.oldv), got.ms);
                    end
                end
            end
        end
        if (!gaps_on) begin
            m_tready <= 1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 5);
            m_tready <= 0;
        end else begin
            m_tready <= 1;
        end
    end

    // watchdog on accepted traffic
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_word(cmd_t c);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tdata <= {1'b0, c};
        s_tvalid <= 1;
        sched_results.push_back(sched_step(c));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // drain, let an idle scan finish, then write age_limit
    task automatic set_age_limit(logic [7:0] v);
        s_tvalid <= 0;
        @(posedge aclk);
        while (sched_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 0;
        age_lim = v;
    endtask

    function automatic cmd_t mk(func_t f, int prio = 0, int sl = 0, int si = 0,
                                int iv = 0, int sc = 0, int tg = 0);
        cmd_t c;
        c.fn = f; c.prio = 8'(prio); c.sleep_ms = 16'(sl); c.sidx = 3'(si);
        c.init_v = 8'(iv); c.scount = 4'(sc); c.target = 4'(tg);
        return c;
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t c;
        int r;
        c = 47'({$urandom, $urandom});
        r = $urandom_range(0, 99);
        // weighted toward a working thread mix
        if (r < 14) c.fn = FN_ADD;
        else if (r < 18) c.fn = FN_KILL;
        else if (r < 24) c.fn = FN_SLEEP;
        else if (r < 40) c.fn = FN_TICK;
        else if (r < 55) c.fn = FN_SCHED;
        else if (r < 59) c.fn = FN_SEMINIT;
        else if (r < 66) c.fn = FN_WAIT;
        else if (r < 72) c.fn = FN_SIGNAL;
        else if (r < 77) c.fn = FN_BWAIT;
        else if (r < 82) c.fn = FN_BSIGNAL;
        else if (r < 87) c.fn = FN_TRY;
        else if (r < 91) c.fn = FN_BTRY;
        else if (r < 97) c.fn = FN_WAKE;
        else c.fn = 4'($urandom_range(13, 15));
        if (c.fn == FN_ADD && $urandom_range(0, 1)) c.prio = 8'($urandom_range(0, 20));
        if (c.fn == FN_SLEEP && $urandom_range(0, 3) != 0)
            c.sleep_ms = 16'($urandom_range(0, 6));
        if (c.fn == FN_SIGNAL && $urandom_range(0, 1)) c.scount = 4'($urandom_range(0, 3));
        if (c.fn == FN_SEMINIT && $urandom_range(0, 1))
            c.init_v = 8'($urandom_range(0, 4) - 2);
        return c;
    endfunction

    typedef struct {
        cmd_t c;
        bit   fixed;
        res_t r;
    } step_row_t;

    step_row_t plan[$];

    initial begin
        res_t exp;
        logic [7:0] lims[4];
        errors = 0; shown = 0; idle_cycles = 0; gaps_on = 1;
        aresetn = 0; cfg_we = 0; cfg_wdata = 0;
        s_tvalid = 0; s_tdata = 0; m_tready = 0;
        sched_reset();
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed rows; fixed result only where obvious
        plan = '{
            '{mk(FN_SCHED), 1, res_t'({32'd0, 8'd0, 1'b1, 1'b0, 4'd0, 1'b0})},
            '{mk(FN_KILL), 1, res_t'(0)},
            '{mk(FN_WAIT, 0, 0, 3), 1, res_t'(0)},
            '{mk(FN_TRY, 0, 0, 7), 1, res_t'(0)},
            '{mk(FN_SEMINIT, 0, 0, 0, -128), 0, res_t'(0)},
            '{mk(FN_SEMINIT, 0, 0, 7, 127), 0, res_t'(0)},
            '{mk(FN_TRY, 0, 0, 0), 1, res_t'({32'd0, 8'h80, 1'b0, 1'b0, 4'd0, 1'b0})},
            '{mk(FN_BTRY, 0, 0, 7), 1, res_t'({32'd0, 8'h7f, 1'b0, 1'b0, 4'd0, 1'b1})},
            '{mk(FN_ADD, 254), 1, res_t'({32'd0, 8'd0, 1'b0, 1'b0, 4'd0, 1'b1})},
            '{mk(FN_ADD, 0), 1, res_t'({32'd0, 8'd0, 1'b0, 1'b0, 4'd1, 1'b1})},
            '{mk(FN_TICK), 1, res_t'({32'd1, 8'd0, 1'b0, 1'b0, 4'd0, 1'b0})},
            '{mk(FN_SCHED), 0, res_t'(0)},
            '{mk(FN_SLEEP, 0, 16'hffff), 0, res_t'(0)},
            '{mk(FN_SCHED), 0, res_t'(0)},
            '{mk(FN_WAKE, 0, 0, 0, 0, 0, 15), 0, res_t'(0)},
            '{mk(FN_WAKE, 0, 0, 0, 0, 0, 1), 0, res_t'(0)},
            '{mk(FN_WAIT, 0, 0, 2), 0, res_t'(0)},
            '{mk(FN_SCHED), 0, res_t'(0)},
            '{mk(FN_BWAIT, 0, 0, 5), 0, res_t'(0)},
            '{mk(FN_SIGNAL, 0, 0, 2, 0, 15), 0, res_t'(0)},
            '{mk(FN_BSIGNAL, 0, 0, 5), 0, res_t'(0)},
            '{mk(FN_SCHED), 0, res_t'(0)},
            '{mk(FN_KILL), 0, res_t'(0)},
            '{mk(func_t'(4'd15)), 0, res_t'(0)}
        };
        foreach (plan[i]) begin
            send_word(plan[i].c);
            if (plan[i].fixed) begin
                exp = sched_results[$];
                if (exp !== plan[i].r) begin
                    errors++;
                    $display("table row %0d: predicted %h, table %h", i, exp, plan[i].r);
                end
            end
        end

        // random phases across age_limit settings; fill table in one phase
        lims = '{8'd0, 8'd255, 8'd3, 8'd8};
        for (int p = 0; p < 4; p++) begin
            set_age_limit(lims[p]);
            for (int n = 0; n < 420; n++) begin
                if (p == 3 && n == 300) begin
                    // wait out all results, then finish without gaps
                    s_tvalid <= 0;
                    @(posedge aclk);
                    while (sched_results.size() != 0) @(posedge aclk);
                    gaps_on = 0;
                end
                if (p == 1 && n < 20) send_word(mk(FN_ADD, $urandom_range(0, 254)));
                else send_word(rand_cmd());
            end
        end
        s_tvalid <= 0;

        while (sched_results.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> files.f
design/pats_pkg.sv
design/pats_slot_eval.sv
design/priority_aging_thread_scheduler_core.sv
design/pats_checker.sv
test/tb_priority_aging_thread_scheduler_core.sv
